[hdl/scfla_pkg.sv]
`timescale 1ns / 1ps

package scfla_pkg;

  localparam int NUM_CLASSES = 11;
  localparam int CLS_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int SIZE_W      = 16;
  localparam int FIELD_AW    = 32;
  localparam int BYTES_W     = 14;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SIZE_W-1:0]   MAX_SIZE     = 16'd8192;
  localparam logic [FIELD_AW-1:0] RESET_LIMIT  = 32'd1048576;

  // input function codes
  localparam logic FUNC_RETRIEVE = 1'b0;
  localparam logic FUNC_RELEASE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LIMIT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FRESH     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REJECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

  // classified operation handed from front to back
  localparam logic [1:0] OP_REJECT   = 2'd0;
  localparam logic [1:0] OP_RETRIEVE = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [CLS_W-1:0]    cls;
    logic [FIELD_AW-1:0] addr;
  } work_t;

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
    logic [BYTES_W-1:0] b;
    case (cls)
      4'd0:    b = 14'd32;
      4'd1:    b = 14'd64;
      4'd2:    b = 14'd128;
      4'd3:    b = 14'd256;
      4'd4:    b = 14'd512;
      4'd5:    b = 14'd1024;
      4'd6:    b = 14'd1536;
      4'd7:    b = 14'd2048;
      4'd8:    b = 14'd3072;
      4'd9:    b = 14'd4096;
      default: b = 14'd8192;
    endcase
    return b;
  endfunction

endpackage

[hdl/scfla_req_if.sv]
`timescale 1ns / 1ps

interface scfla_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] req_size;
  logic [31:0] block_addr;

  modport source(output valid, func, req_size, block_addr, input ready);
  modport sink(input valid, func, req_size, block_addr, output ready);
endinterface

[hdl/scfla_rsp_if.sv]
`timescale 1ns / 1ps

interface scfla_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] grant_addr;
  logic [3:0]  size_class;
  logic [2:0]  status;

  modport source(output valid, grant_addr, size_class, status, input ready);
  modport sink(input valid, grant_addr, size_class, status, output ready);
endinterface

[hdl/scfla_ram.sv]
`timescale 1ns / 1ps

module scfla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2816
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/scfla_queue.sv]
`timescale 1ns / 1ps

module scfla_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  scfla_pkg::work_t  push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output scfla_pkg::work_t  pop_data,
  input  logic              pop
);
  import scfla_pkg::*;

  // two-entry queue between classifier and executor
  work_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/scfla_front.sv]
`timescale 1ns / 1ps

module scfla_front #(
  parameter int ADDR_WIDTH = 32
) (
  scfla_req_if.sink         req,
  output logic              push_valid,
  output scfla_pkg::work_t  push_data,
  input  logic              push_ready
);
  import scfla_pkg::*;

  localparam int AW = (ADDR_WIDTH < FIELD_AW) ? ADDR_WIDTH : FIELD_AW;
  localparam logic [FIELD_AW-1:0] ADDR_MASK = FIELD_AW'((64'(1) << AW) - 64'(1));

  logic [CLS_W-1:0]    cls;
  logic                size_ok;
  logic [FIELD_AW-1:0] addr;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign size_ok    = (req.req_size != '0) && (req.req_size <= MAX_SIZE);
  assign addr       = req.block_addr & ADDR_MASK;

  // smallest class that holds the size
  always_comb begin
    cls = CLS_W'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
      if (req.req_size <= SIZE_W'(class_bytes(CLS_W'(c)))) begin
        cls = CLS_W'(c);
      end
    end
  end

  always_comb begin
    push_data.addr = addr;
    push_data.cls  = cls;
    if (!size_ok) begin
      push_data.op  = OP_REJECT;
      push_data.cls = '0;
    end else if (req.func == FUNC_RETRIEVE) begin
      push_data.op = OP_RETRIEVE;
    end else if (addr == '0) begin
      push_data.op  = OP_REJECT;
      push_data.cls = '0;
    end else begin
      push_data.op = OP_RELEASE;
    end
  end

endmodule

[hdl/scfla_back.sv]
`timescale 1ns / 1ps

module scfla_back #(
  parameter int CLASS_DEPTH = 256,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  scfla_pkg::work_t                     q_data,
  output logic                                 q_pop,
  input  logic                                 cfg_we,
  input  logic [scfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scfla_pkg::FIELD_AW-1:0]       cfg_wdata,
  scfla_rsp_if.source                          rsp
);
  import scfla_pkg::*;

  localparam int AW        = (ADDR_WIDTH < FIELD_AW) ? ADDR_WIDTH : FIELD_AW;
  localparam int HW        = $clog2(CLASS_DEPTH);
  localparam int CW        = $clog2(CLASS_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int MAW       = $clog2(MEM_DEPTH);

  localparam logic S_RUN  = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                state;
  logic [FIELD_AW-1:0] region_limit;
  logic [AW-1:0]       bump;
  logic [HW-1:0]       head  [NUM_CLASSES];
  logic [CW-1:0]       count [NUM_CLASSES];
  logic [CLS_W-1:0]    read_cls;

  logic [HW-1:0]       cur_head;
  logic [CW-1:0]       cur_count;
  logic [HW-1:0]       head_inc;
  logic [CW:0]         tail_sum;
  logic [HW-1:0]       tail;
  logic                list_empty;
  logic                list_full;
  logic [MAW-1:0]      cls_base;
  logic [BYTES_W-1:0]  sz;
  logic [FIELD_AW:0]   fresh_end;
  logic                exhausted;
  logic                fire;
  logic                is_reuse;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_rdata;

  logic [FIELD_AW-1:0] res_grant;
  logic [CLS_W-1:0]    res_cls;
  logic [STATUS_W-1:0] res_status;

  assign cur_head   = head[q_data.cls];
  assign cur_count  = count[q_data.cls];
  assign list_empty = (cur_count == '0);
  assign list_full  = (cur_count == CW'(CLASS_DEPTH));
  assign head_inc   = (cur_head == HW'(CLASS_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign tail_sum   = (CW+1)'(cur_head) + (CW+1)'(cur_count);
  assign tail       = (tail_sum >= (CW+1)'(CLASS_DEPTH)) ?
                      HW'(tail_sum - (CW+1)'(CLASS_DEPTH)) : HW'(tail_sum);
  assign cls_base   = MAW'(q_data.cls) * MAW'(CLASS_DEPTH);

  // fresh block check in full precision, no wrap
  assign sz         = class_bytes(q_data.cls);
  assign fresh_end  = (FIELD_AW+1)'(bump) + (FIELD_AW+1)'(sz);
  assign exhausted  = fresh_end > (FIELD_AW+1)'(region_limit);

  assign fire     = (state == S_RUN) && q_valid && (!rsp.valid || rsp.ready);
  assign q_pop    = fire;
  assign is_reuse = (q_data.op == OP_RETRIEVE) && !list_empty;
  assign mem_re   = fire && is_reuse;
  assign mem_we   = fire && (q_data.op == OP_RELEASE) && !list_full;

  scfla_ram #(
    .WIDTH (AW),
    .DEPTH (MEM_DEPTH)
  ) u_free_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cls_base + MAW'(tail)),
    .wdata (AW'(q_data.addr)),
    .re    (mem_re),
    .raddr (cls_base + MAW'(cur_head)),
    .rdata (mem_rdata)
  );

  always_comb begin
    res_grant  = '0;
    res_cls    = q_data.cls;
    res_status = STAT_REJECTED;
    unique case (q_data.op)
      OP_RETRIEVE: begin
        if (exhausted) begin
          res_status = STAT_EXHAUSTED;
        end else begin
          res_grant  = FIELD_AW'(bump);
          res_status = STAT_FRESH;
        end
      end
      OP_RELEASE: begin
        res_status = list_full ? STAT_FULL : STAT_RELEASED;
      end
      default: begin
        res_cls    = '0;
        res_status = STAT_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      rsp.valid    <= 1'b0;
      region_limit <= RESET_LIMIT;
      bump         <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REGION_BASE: bump <= AW'(cfg_wdata);
          REG_REGION_LIMIT: region_limit <= cfg_wdata;
          default: ;
        endcase
      end
      if ((fire && !is_reuse) || (state == S_READ)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (fire) begin
            if (is_reuse) begin
              head[q_data.cls]  <= head_inc;
              count[q_data.cls] <= cur_count - 1'b1;
              state             <= S_READ;
            end else begin
              if (q_data.op == OP_RETRIEVE && !exhausted) begin
                bump <= AW'(fresh_end);
              end
              if (mem_we) begin
                count[q_data.cls] <= cur_count + 1'b1;
              end
            end
          end
        end
        S_READ: begin
          state <= S_RUN;
        end
        default: state <= S_RUN;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      read_cls <= q_data.cls;
    end
    if (fire && !is_reuse) begin
      rsp.grant_addr <= res_grant;
      rsp.size_class <= res_cls;
      rsp.status     <= res_status;
    end else if (state == S_READ) begin
      rsp.grant_addr <= FIELD_AW'(mem_rdata);
      rsp.size_class <= read_cls;
      rsp.status     <= STAT_REUSED;
    end
  end

endmodule

[hdl/size_class_free_list_allocator_unit.sv]
`timescale 1ns / 1ps

// channel  dir  fields                             beat taken when
// req      in   func, req_size, block_addr         req.valid && req.ready
// rsp      out  grant_addr, size_class, status     rsp.valid && rsp.ready
// cfg      in   cfg_index, cfg_wdata               cfg_we
//
// the front classifies a beat in its accept cycle and queues it (two entries)
// the back executes one queued item per cycle while rsp is not stalled; a retrieve
// served from a free list also holds the back in S_READ, since the free-store read is registered
// one result per item, held in an output register until taken
// reset clears list heads and fill counts at once; no clearing pass
// a stalled rsp holds the back, while the front keeps filling the queue

module size_class_free_list_allocator_unit #(
  parameter int CLASS_DEPTH = 256,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  scfla_req_if.sink                       req,
  scfla_rsp_if.source                     rsp,
  input  logic                            cfg_we,
  input  logic [scfla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scfla_pkg::FIELD_AW-1:0]  cfg_wdata
);
  import scfla_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_data;
  logic  q_valid;
  work_t q_data;
  logic  q_pop;

  scfla_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  scfla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  scfla_back #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule
